[design/ast_pkg.sv]
// alarm slot table shared types, constants and helpers
// used by ast_ram users and alarm_slot_table_core; depends on nothing
`default_nettype none
package ast_pkg;

  localparam int unsigned SLOT_COUNT = 16;
  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int unsigned TALLY_W = 5;
  localparam int unsigned TALLY_MAX = 31;

  localparam logic [63:0] DEFAULT_PERIOD = 64'd86400 * 64'd1000000;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_TICK   = 3'd2,
    OP_GET    = 3'd3,
    OP_COUNT  = 3'd4,
    OP_CLEAR  = 3'd5
  } ast_op_e;

  typedef enum logic [2:0] {
    K_ADD     = 3'd0,
    K_REMOVE  = 3'd1,
    K_FIRE    = 3'd2,
    K_SUMMARY = 3'd3,
    K_GET     = 3'd4,
    K_COUNT   = 3'd5
  } ast_kind_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [63:0] lookup_id;
    logic [63:0] start_time;
    logic [63:0] now_time;
    logic        enable_flag;
    logic        repeat_flag;
    logic [31:0] payload;
  } ast_req_t;

  typedef struct packed {
    logic [2:0]         result_kind;
    logic               status;
    logic [63:0]        entry_id;
    logic [63:0]        entry_start;
    logic               entry_enabled;
    logic               entry_repeat;
    logic [31:0]        entry_payload;
    logic [TALLY_W-1:0] tally;
    logic               last;
  } ast_res_t;

  // one slot as held in the table memory
  typedef struct packed {
    logic [63:0] id;
    logic [63:0] start;
    logic        enabled;
    logic        rep;
    logic [31:0] payload;
  } ast_slot_t;

  localparam int unsigned SLOT_W = $bits(ast_slot_t);

  function automatic logic [TALLY_W-1:0] sat_tally(input logic [CNT_W-1:0] cnt);
    logic [31:0] wide;
    wide = 32'(cnt);
    if (wide > TALLY_MAX) begin
      return TALLY_W'(TALLY_MAX);
    end
    return wide[TALLY_W-1:0];
  endfunction

endpackage
`default_nettype wire

[design/ast_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module ast_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[design/alarm_slot_table_core.sv]
// alarm slot table top level: used bits in flops, slot contents in one ram
// depends on ast_pkg and ast_ram
//
//  channel   ports                                  handshake
//  request   start, busy, req_i                     start && !busy
//  config    cfg_valid_i, cfg_ready_o, cfg_data_i   cfg_valid_i && cfg_ready_o
//  result    res_strobe_o, res_o                    strobe, one cycle, no stall
//
// add, count and clear need no table walk; the result strobes on the next cycle.
// remove and get walk the table memory one slot a cycle, stopping at the first
// match. tick walks every slot, with one fire result per firing slot, then the
// summary. the walk rate is set by the single read port of the slot memory.
// reset clears the used bits at once, so no clearing pass is needed.
`default_nettype none
module alarm_slot_table_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire ast_pkg::ast_req_t req_i,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [63:0]      cfg_data_i,
  output logic                  res_strobe_o,
  output ast_pkg::ast_res_t     res_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SUMM
  } state_e;

  localparam int unsigned IW = ast_pkg::IDX_W;
  localparam int unsigned CW = ast_pkg::CNT_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(ast_pkg::SLOT_COUNT - 1);

  state_e                         state_q;
  logic [ast_pkg::SLOT_COUNT-1:0] used_q;
  logic [CW-1:0]                  used_cnt_q;
  logic [CW-1:0]                  fire_q;
  logic [IW-1:0]                  chk_q;
  logic [2:0]                     op_q;
  logic [63:0]                    lookup_q;
  logic [63:0]                    now_q;
  logic [63:0]                    next_id_q;
  logic [63:0]                    period_q;
  logic                           res_strobe_q;
  ast_pkg::ast_res_t              res_q;

  logic                           accept;
  logic                           ram_we;
  logic [IW-1:0]                  ram_waddr;
  ast_pkg::ast_slot_t             ram_wdata;
  logic [IW-1:0]                  ram_raddr;
  ast_pkg::ast_slot_t             rdata;
  logic                           full;
  logic [IW-1:0]                  free_idx;
  logic                           is_last;
  logic                           id_hit;
  logic                           fire;
  logic [63:0]                    next_id_inc;

  assign accept       = start && !busy;
  assign busy         = (state_q != S_IDLE);
  assign cfg_ready_o  = 1'b1;
  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

  assign full        = &used_q;
  assign is_last     = (chk_q == LAST_IDX);
  assign id_hit      = used_q[chk_q] && (rdata.id == lookup_q);
  assign fire        = used_q[chk_q] && rdata.enabled && !(rdata.start > now_q);
  assign next_id_inc = next_id_q + 64'd1;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = ast_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  // read one slot ahead of the one being checked
  always_comb begin
    if (state_q == S_IDLE) begin
      ram_raddr = '0;
    end else if (is_last) begin
      ram_raddr = chk_q;
    end else begin
      ram_raddr = chk_q + IW'(1);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = chk_q;
    ram_wdata = rdata;
    if (state_q == S_IDLE) begin
      ram_waddr         = free_idx;
      ram_wdata.id      = next_id_q;
      ram_wdata.start   = req_i.start_time;
      ram_wdata.enabled = req_i.enable_flag;
      ram_wdata.rep     = req_i.repeat_flag;
      ram_wdata.payload = req_i.payload;
      ram_we            = accept && (req_i.operation == ast_pkg::OP_ADD) && !full;
    end else if (state_q == S_SCAN) begin
      // advance a repeating entry that fires
      ram_wdata.start = rdata.start + period_q;
      ram_we          = (op_q == ast_pkg::OP_TICK) && fire && rdata.rep;
    end
  end

  ast_ram #(
    .WIDTH(ast_pkg::SLOT_W),
    .DEPTH(ast_pkg::SLOT_COUNT)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      used_q       <= '0;
      used_cnt_q   <= '0;
      fire_q       <= '0;
      chk_q        <= '0;
      op_q         <= '0;
      lookup_q     <= '0;
      now_q        <= '0;
      next_id_q    <= 64'd1;
      period_q     <= ast_pkg::DEFAULT_PERIOD;
      res_strobe_q <= 1'b0;
      res_q        <= '0;
    end else begin
      res_strobe_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        period_q <= cfg_data_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q     <= req_i.operation;
            lookup_q <= req_i.lookup_id;
            now_q    <= req_i.now_time;
            chk_q    <= '0;
            fire_q   <= '0;
            res_q    <= '0;
            res_q.last <= 1'b1;
            unique case (req_i.operation)
              ast_pkg::OP_ADD: begin
                res_strobe_q      <= 1'b1;
                res_q.result_kind <= ast_pkg::K_ADD;
                if (full) begin
                  res_q.status <= ast_pkg::ST_FAIL;
                end else begin
                  res_q.status       <= ast_pkg::ST_OK;
                  res_q.entry_id     <= next_id_q;
                  used_q[free_idx]   <= 1'b1;
                  used_cnt_q         <= used_cnt_q + CW'(1);
                  // ids skip zero on wrap
                  next_id_q <= (next_id_inc == 64'd0) ? 64'd1 : next_id_inc;
                end
              end
              ast_pkg::OP_REMOVE, ast_pkg::OP_GET, ast_pkg::OP_TICK: begin
                state_q <= S_SCAN;
              end
              ast_pkg::OP_COUNT: begin
                res_strobe_q      <= 1'b1;
                res_q.result_kind <= ast_pkg::K_COUNT;
                res_q.tally       <= ast_pkg::sat_tally(used_cnt_q);
              end
              ast_pkg::OP_CLEAR: begin
                res_strobe_q      <= 1'b1;
                res_q.result_kind <= ast_pkg::K_COUNT;
                used_q            <= '0;
                used_cnt_q        <= '0;
              end
              default: begin
                // unknown operation: no result
              end
            endcase
          end
        end
        S_SCAN: begin
          chk_q <= chk_q + IW'(1);
          res_q <= '0;
          if (op_q == ast_pkg::OP_TICK) begin
            if (fire) begin
              res_strobe_q        <= 1'b1;
              res_q.result_kind   <= ast_pkg::K_FIRE;
              res_q.status        <= ast_pkg::ST_OK;
              res_q.entry_id      <= rdata.id;
              res_q.entry_start   <= rdata.start;
              res_q.entry_enabled <= 1'b1;
              res_q.entry_repeat  <= rdata.rep;
              res_q.entry_payload <= rdata.payload;
              fire_q              <= fire_q + CW'(1);
              if (!rdata.rep) begin
                used_q[chk_q] <= 1'b0;
                used_cnt_q    <= used_cnt_q - CW'(1);
              end
            end
            if (is_last) begin
              state_q <= S_SUMM;
            end
          end else begin
            res_q.last <= 1'b1;
            res_q.result_kind <= (op_q == ast_pkg::OP_GET) ? ast_pkg::K_GET
                                                           : ast_pkg::K_REMOVE;
            if (id_hit) begin
              res_strobe_q <= 1'b1;
              res_q.status <= ast_pkg::ST_OK;
              state_q      <= S_IDLE;
              if (op_q == ast_pkg::OP_GET) begin
                res_q.entry_id      <= rdata.id;
                res_q.entry_start   <= rdata.start;
                res_q.entry_enabled <= rdata.enabled;
                res_q.entry_repeat  <= rdata.rep;
                res_q.entry_payload <= rdata.payload;
              end else begin
                res_q.entry_id <= lookup_q;
                used_q[chk_q]  <= 1'b0;
                used_cnt_q     <= used_cnt_q - CW'(1);
              end
            end else if (is_last) begin
              res_strobe_q <= 1'b1;
              res_q.status <= ast_pkg::ST_FAIL;
              state_q      <= S_IDLE;
            end
          end
        end
        S_SUMM: begin
          res_strobe_q      <= 1'b1;
          res_q             <= '0;
          res_q.result_kind <= ast_pkg::K_SUMMARY;
          res_q.tally       <= ast_pkg::sat_tally(fire_q);
          res_q.last        <= 1'b1;
          state_q           <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // the running used count tracks the used bits
  a_used_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_cnt_q) == $countones(used_q))
    else $error("used slot count out of step with used bits");

  // the final result of a request leaves the block idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_q && res_q.last |-> state_q == S_IDLE)
    else $error("last result while still busy");

  // a tick request always starts a table walk
  a_tick_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.operation == ast_pkg::OP_TICK |=> state_q == S_SCAN)
    else $error("tick request did not start a walk");

  // only enabled entries fire
  a_fire_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_q && res_q.result_kind == ast_pkg::K_FIRE |-> res_q.entry_enabled)
    else $error("fire result for a disabled entry");
`endif

endmodule
`default_nettype wire
